// ===== design/jsu_pkg.sv =====
`default_nettype none
package jsu_pkg;

	localparam int MaxResults = 3;

	typedef enum logic [1:0] {
		ST_DATA  = 2'd0,
		ST_DONE  = 2'd1,
		ST_ERROR = 2'd2
	} jsu_status_t;

	typedef enum logic [2:0] {
		MODE_NORMAL = 3'd0,
		MODE_ESCAPE = 3'd1,
		MODE_HEX0   = 3'd2,
		MODE_HEX1   = 3'd3,
		MODE_HEX2   = 3'd4,
		MODE_HEX3   = 3'd5
	} jsu_mode_t;

	localparam logic [7:0] ChQuote     = 8'h22;
	localparam logic [7:0] ChBackslash = 8'h5C;
	localparam logic [7:0] ChSlash     = 8'h2F;
	localparam logic [7:0] ChB         = 8'h62;
	localparam logic [7:0] ChF         = 8'h66;
	localparam logic [7:0] ChN         = 8'h6E;
	localparam logic [7:0] ChR         = 8'h72;
	localparam logic [7:0] ChT         = 8'h74;
	localparam logic [7:0] ChU         = 8'h75;

	typedef struct packed {
		logic [7:0] byte_in;
		logic       end_of_data;
	} jsu_in_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		jsu_status_t status;
		logic        last;
	} jsu_out_t;

	typedef struct packed {
		logic [1:0]                    cnt;
		jsu_out_t [MaxResults-1:0]     res;
	} jsu_group_t;

	function automatic jsu_out_t mk_word(logic [7:0] b, jsu_status_t st, logic lst);
		jsu_out_t w;
		w.out_byte = b;
		w.status   = st;
		w.last     = lst;
		return w;
	endfunction

	// {valid, value}
	function automatic logic [4:0] hex_value(logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== design/jsu_decoder.sv =====
`default_nettype none
module jsu_decoder
	import jsu_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       take,
	input  wire jsu_in_t    word,
	input  wire logic       permit_nul,
	output jsu_group_t      grp
);

	jsu_mode_t   mode_q, mode_d;
	logic [15:0] accum_q, accum_d;
	logic [4:0]  hv;
	logic [15:0] code;
	logic [7:0]  c;

	assign c    = word.byte_in;
	assign hv   = hex_value(c);
	assign code = {accum_q[11:0], hv[3:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_NORMAL;
			accum_q <= 16'd0;
		end else if (take) begin
			mode_q  <= mode_d;
			accum_q <= accum_d;
		end
	end

	// next state
	always_comb begin
		mode_d  = MODE_NORMAL;
		accum_d = 16'd0;
		if (!word.end_of_data) begin
			unique case (mode_q)
				MODE_ESCAPE: begin
					if (c == ChU) begin
						mode_d = MODE_HEX0;
					end else begin
						accum_d = accum_q;
					end
				end
				MODE_HEX0, MODE_HEX1, MODE_HEX2: begin
					if (hv[4]) begin
						mode_d  = jsu_mode_t'(mode_q + 3'd1);
						accum_d = code;
					end
				end
				MODE_HEX3: begin
				end
				default: begin
					accum_d = accum_q;
					if (c == ChBackslash) begin
						mode_d = MODE_ESCAPE;
					end else if (c == ChQuote || (c == 8'h00 && !permit_nul)) begin
						accum_d = 16'd0;
					end
				end
			endcase
		end
	end

	// result group
	always_comb begin
		grp.cnt = 2'd0;
		grp.res = '0;
		if (word.end_of_data) begin
			grp.cnt    = 2'd1;
			grp.res[0] = mk_word(8'h00, ST_ERROR, 1'b1);
		end else begin
			unique case (mode_q)
				MODE_ESCAPE: begin
					grp.cnt = 2'd1;
					unique case (c)
						ChQuote:     grp.res[0] = mk_word(ChQuote, ST_DATA, 1'b1);
						ChBackslash: grp.res[0] = mk_word(ChBackslash, ST_DATA, 1'b1);
						ChSlash:     grp.res[0] = mk_word(ChSlash, ST_DATA, 1'b1);
						ChB:         grp.res[0] = mk_word(8'h08, ST_DATA, 1'b1);
						ChF:         grp.res[0] = mk_word(8'h0C, ST_DATA, 1'b1);
						ChN:         grp.res[0] = mk_word(8'h0A, ST_DATA, 1'b1);
						ChR:         grp.res[0] = mk_word(8'h0D, ST_DATA, 1'b1);
						ChT:         grp.res[0] = mk_word(8'h09, ST_DATA, 1'b1);
						ChU:         grp.cnt    = 2'd0;
						default:     grp.res[0] = mk_word(8'h00, ST_ERROR, 1'b1);
					endcase
				end
				MODE_HEX0, MODE_HEX1, MODE_HEX2: begin
					if (!hv[4]) begin
						grp.cnt    = 2'd1;
						grp.res[0] = mk_word(8'h00, ST_ERROR, 1'b1);
					end
				end
				MODE_HEX3: begin
					if (!hv[4] || (code == 16'd0 && !permit_nul) ||
					    code[15:11] == 5'b11011) begin
						grp.cnt    = 2'd1;
						grp.res[0] = mk_word(8'h00, ST_ERROR, 1'b1);
					end else if (code[15:7] == 9'd0) begin
						grp.cnt    = 2'd1;
						grp.res[0] = mk_word(code[7:0], ST_DATA, 1'b1);
					end else if (code[15:11] == 5'd0) begin
						grp.cnt    = 2'd2;
						grp.res[0] = mk_word({3'b110, code[10:6]}, ST_DATA, 1'b0);
						grp.res[1] = mk_word({2'b10, code[5:0]}, ST_DATA, 1'b1);
					end else begin
						grp.cnt    = 2'd3;
						grp.res[0] = mk_word({4'b1110, code[15:12]}, ST_DATA, 1'b0);
						grp.res[1] = mk_word({2'b10, code[11:6]}, ST_DATA, 1'b0);
						grp.res[2] = mk_word({2'b10, code[5:0]}, ST_DATA, 1'b1);
					end
				end
				default: begin
					if (c == ChQuote) begin
						grp.cnt    = 2'd1;
						grp.res[0] = mk_word(8'h00, ST_DONE, 1'b1);
					end else if (c == ChBackslash) begin
						grp.cnt = 2'd0;
					end else if (c == 8'h00 && !permit_nul) begin
						grp.cnt    = 2'd1;
						grp.res[0] = mk_word(8'h00, ST_ERROR, 1'b1);
					end else begin
						grp.cnt    = 2'd1;
						grp.res[0] = mk_word(c, ST_DATA, 1'b1);
					end
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== design/json_string_unescaper_unit.sv =====
`default_nettype none
// JSON string body unescaper with UTF-8 output.
// Input channel: in_valid/in_stall/in_word carries one body byte per word
// (opening quote already consumed), or an end_of_data mark. Output channel:
// out_valid/out_stall/out_word carries decoded bytes, a done word on the
// closing quote, or an error word; last marks the final word of an input.
// cfg_we/cfg_data write permit_nul; write it only while the block is idle.
// Each input word is decoded in the cycle it is accepted and its results
// (zero to three words) go into a two-group result queue. One input word
// per cycle is taken while the queue has room; the output side drains one
// word per cycle while out_stall is low, so a \u escape that expands to
// three bytes leaves as three successive output words. in_stall rises only
// when both queue groups are occupied.
// While out_stall is high the head word holds and input is taken until the
// queue fills. Reset clears the decode mode, the code accumulator, the
// queue and permit_nul.
module json_string_unescaper_unit
	import jsu_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_stall,
	input  wire jsu_in_t in_word,
	output logic         out_valid,
	input  wire logic    out_stall,
	output jsu_out_t     out_word,
	input  wire logic    cfg_we,
	input  wire logic    cfg_data
);

	logic       permit_nul_q;
	logic       in_take, out_take, push, pop;
	jsu_group_t dec_grp;
	jsu_group_t grp_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic [1:0] idx_q;
	logic [1:0] head_cnt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			permit_nul_q <= 1'b0;
		end else if (cfg_we) begin
			permit_nul_q <= cfg_data;
		end
	end

	assign in_stall = (cnt_q == 2'd2);
	assign in_take  = in_valid && !in_stall;

	jsu_decoder u_dec (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (in_take),
		.word       (in_word),
		.permit_nul (permit_nul_q),
		.grp        (dec_grp)
	);

	assign head_cnt  = grp_q[rd_ptr_q].cnt;
	assign out_valid = (cnt_q != 2'd0);
	assign out_word  = grp_q[rd_ptr_q].res[idx_q];
	assign out_take  = out_valid && !out_stall;
	assign push      = in_take && (dec_grp.cnt != 2'd0);
	assign pop       = out_take && (idx_q == 2'(head_cnt - 2'd1));

	always_ff @(posedge clk) begin
		if (push) begin
			grp_q[wr_ptr_q] <= dec_grp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
			idx_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
				idx_q    <= 2'd0;
			end else if (out_take) begin
				idx_q <= idx_q + 2'd1;
			end
			cnt_q <= 2'(cnt_q + {1'b0, push} - {1'b0, pop});
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result queue count out of range");

	a_idx_in_group: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (idx_q < head_cnt))
		else $error("result index beyond group");

	a_last_matches: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_word.last == (idx_q == 2'(head_cnt - 2'd1))))
		else $error("last flag does not match group end");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(idx_q) && $stable(rd_ptr_q)))
		else $error("head word moved while stalled");

endmodule
`default_nettype wire
